// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the frame builder RTL, used by ssfb_emit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising aclk edge, off while aresetn is low.
`define SSFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be seen on a clock edge.
`define SSFB_ASSERT_NEVER(label, cond, msg) \
    `SSFB_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/ssfb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfb_pkg
// Shared types, constants and lookup functions of the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfb_pkg;

    // function codes carried in the input tuser
    localparam logic [1:0] FUNC_NUMBER = 2'd0;
    localparam logic [1:0] FUNC_DIGIT  = 2'd1;
    localparam logic [1:0] FUNC_RAW    = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam int NUM_W = 14;                       // holds 0..9999
    localparam logic [NUM_W-1:0] NUMBER_MAX = 14'd9999;
    localparam logic [NUM_W-1:0] W_THOU     = 14'd1000;
    localparam logic [NUM_W-1:0] W_HUND     = 14'd100;
    localparam logic [NUM_W-1:0] W_TEN      = 14'd10;

    localparam logic [5:0] FRAME_FILL = 6'h3f;
    localparam int OUT_DATA_W = 24;

    // segment bytes for decimal digits (A=4 B=6 C=1 D=2 E=3 F=5 G=0)
    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'h7e, 8'h42, 8'h5d, 8'h57, 8'h63,
        8'h37, 8'h3f, 8'h52, 8'h7f, 8'h77
    };

    // up to four segment bytes, kept by display slot (slot 3 = units)
    typedef struct packed {
        logic [3:0][7:0] seg;
        logic [1:0]      cnt_m1;   // frames minus one
        logic [2:0]      pos0;     // position of the first frame
    } set_t;

    // active-low digit select nibble
    function automatic logic [3:0] select_nibble(input logic [2:0] pos);
        logic [3:0] nib;
        case (pos)
            3'd1:    nib = 4'hd;
            3'd2:    nib = 4'hb;
            3'd3:    nib = 4'h7;
            3'd4:    nib = 4'he;
            default: nib = 4'hf;
        endcase
        return nib;
    endfunction

    // leading decimal digit of r for a place weight w, by parallel compares
    function automatic logic [3:0] digit_of(input logic [NUM_W-1:0] r,
                                            input logic [NUM_W-1:0] w);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (r >= NUM_W'(i) * w) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ssfb_split.sv -----
// ----------------------------------------------------------------------------
// ssfb_split
// Input register, clamp and three-stage decimal split into a frame set.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfb_split (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [31:0] value,
    input  wire logic [2:0]         position,
    input  wire logic [7:0]         segments,
    output logic                    set_valid,
    input  wire logic               set_ready,
    output ssfb_pkg::set_t          set_data
);

    localparam int NW = ssfb_pkg::NUM_W;

    // input side: clamp and single-digit segment lookup
    logic          neg;
    logic [NW-1:0] n_in;
    logic [3:0]    digit_in;
    logic [7:0]    seg_in;
    logic          keep;

    always_comb begin
        neg = value[31];
        if (neg) begin
            n_in = '0;
        end else if (value > 32'sd9999) begin
            n_in = ssfb_pkg::NUMBER_MAX;
        end else begin
            n_in = value[NW-1:0];
        end
        digit_in = (!neg && value <= 32'sd9) ? value[3:0] : 4'd0;
        seg_in   = (func == ssfb_pkg::FUNC_RAW) ? segments : ssfb_pkg::DIGIT_SEG[digit_in];
        keep     = (func != ssfb_pkg::FUNC_NONE);
    end

    // stage registers
    logic          v0_reg, v1_reg, v2_reg;
    logic          num0_reg, num1_reg, num2_reg;
    logic [NW-1:0] n0_reg;
    logic [9:0]    r1_reg;
    logic [6:0]    r2_reg;
    logic [3:0]    dth1_reg, dth2_reg, dh2_reg;
    logic [2:0]    pos0_reg, pos1_reg, pos2_reg;
    logic [7:0]    seg0_reg, seg1_reg, seg2_reg;

    logic ready0, ready1, ready2;
    assign ready2   = !v2_reg || set_ready;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;

    logic [3:0]    dth_s1, dh_s2;
    logic [NW-1:0] rem_s1, rem_s2;

    always_comb begin
        dth_s1 = ssfb_pkg::digit_of(n0_reg, ssfb_pkg::W_THOU);
        rem_s1 = n0_reg - NW'(dth_s1) * ssfb_pkg::W_THOU;
        dh_s2  = ssfb_pkg::digit_of(NW'(r1_reg), ssfb_pkg::W_HUND);
        rem_s2 = NW'(r1_reg) - NW'(dh_s2) * ssfb_pkg::W_HUND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready0) begin
                v0_reg <= in_valid && keep;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
        if (ready0) begin
            num0_reg <= (func == ssfb_pkg::FUNC_NUMBER);
            n0_reg   <= n_in;
            pos0_reg <= position;
            seg0_reg <= seg_in;
        end
        if (ready1) begin
            num1_reg <= num0_reg;
            dth1_reg <= dth_s1;
            r1_reg   <= rem_s1[9:0];
            pos1_reg <= pos0_reg;
            seg1_reg <= seg0_reg;
        end
        if (ready2) begin
            num2_reg <= num1_reg;
            dth2_reg <= dth1_reg;
            dh2_reg  <= dh_s2;
            r2_reg   <= rem_s2[6:0];
            pos2_reg <= pos1_reg;
            seg2_reg <= seg1_reg;
        end
    end

    // last stage: tens and units, frame count, slot bytes
    logic [3:0]    dt_s3, du_s3;
    logic [NW-1:0] rem_s3;
    logic [1:0]    cnt_m1;

    always_comb begin
        dt_s3  = ssfb_pkg::digit_of(NW'(r2_reg), ssfb_pkg::W_TEN);
        rem_s3 = NW'(r2_reg) - NW'(dt_s3) * ssfb_pkg::W_TEN;
        du_s3  = rem_s3[3:0];
        if (dth2_reg != 4'd0) begin
            cnt_m1 = 2'd3;
        end else if (dh2_reg != 4'd0) begin
            cnt_m1 = 2'd2;
        end else if (dt_s3 != 4'd0) begin
            cnt_m1 = 2'd1;
        end else begin
            cnt_m1 = 2'd0;
        end
        if (num2_reg) begin
            set_data.seg[0] = ssfb_pkg::DIGIT_SEG[dth2_reg];
            set_data.seg[1] = ssfb_pkg::DIGIT_SEG[dh2_reg];
            set_data.seg[2] = ssfb_pkg::DIGIT_SEG[dt_s3];
            set_data.seg[3] = ssfb_pkg::DIGIT_SEG[du_s3];
            set_data.cnt_m1 = cnt_m1;
            set_data.pos0   = 3'd4 - {1'b0, cnt_m1};
        end else begin
            set_data.seg    = {4{seg2_reg}};
            set_data.cnt_m1 = 2'd0;
            set_data.pos0   = pos2_reg;
        end
    end

    assign set_valid = v2_reg;

endmodule

`default_nettype wire

// ----- rtl/ssfb_emit.sv -----
// ----------------------------------------------------------------------------
// ssfb_emit
// Holds one frame set and sends its frames through the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssfb_emit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                set_valid,
    output logic                                     set_ready,
    input  wire ssfb_pkg::set_t                      set_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [ssfb_pkg::OUT_DATA_W-1:0]          out_data,
    output logic                                     out_last
);

    logic           hold_reg;      // a set is loaded
    ssfb_pkg::set_t set_reg;
    logic [1:0]     k_reg;         // next frame of the set
    logic           out_valid_reg;
    logic [ssfb_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic           out_last_reg;

    logic       out_adv, take, frame_last;
    logic [1:0] slot;
    logic [2:0] pos;
    logic [17:0] frame;
    logic [ssfb_pkg::OUT_DATA_W-1:0] out_data_next;

    always_comb begin
        out_adv    = !out_valid_reg || out_ready;
        take       = hold_reg && out_adv;
        frame_last = (k_reg == set_reg.cnt_m1);
        set_ready  = !hold_reg || (take && frame_last);
        slot       = k_reg + (2'd3 - set_reg.cnt_m1);
        pos        = set_reg.pos0 + {1'b0, k_reg};
        frame      = {ssfb_pkg::select_nibble(pos), ssfb_pkg::FRAME_FILL, set_reg.seg[slot]};
        out_data_next = {3'b000, pos, frame};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= 1'b0;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (set_ready) begin
                hold_reg <= set_valid;
                k_reg    <= 2'd0;
            end else if (take) begin
                k_reg <= k_reg + 2'd1;
            end
            if (out_adv) begin
                out_valid_reg <= hold_reg;
            end
        end
        if (set_ready && set_valid) begin
            set_reg <= set_data;
        end
        if (take) begin
            out_data_reg <= out_data_next;
            out_last_reg <= frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    `SSFB_ASSERT(a_k_in_set, hold_reg |-> k_reg <= set_reg.cnt_m1, "frame index beyond set")
    `SSFB_ASSERT(a_set_held, take && !frame_last |=> hold_reg, "set dropped before last frame")
    `SSFB_ASSERT(a_fill, out_valid_reg |-> out_data_reg[13:8] == ssfb_pkg::FRAME_FILL, "bad fill bits")
    `SSFB_ASSERT(a_inner_pos, out_valid_reg && !out_last_reg |-> (out_data_reg[20:18] == 3'd1 || out_data_reg[20:18] == 3'd2 || out_data_reg[20:18] == 3'd3), "bad inner position")

endmodule

`default_nettype wire

// ----- rtl/seven_segment_frame_builder.sv -----
// ----------------------------------------------------------------------------
// seven_segment_frame_builder
// Turns display commands into 18-bit serial frames for a 4-digit LED driver.
// ----------------------------------------------------------------------------
// Input transfer: tuser = function (show number, show digit, raw byte, unused),
//   tdata = value, position, segment byte. Output transfer: one frame per beat,
//   tdata = frame and its digit position, tlast on the final frame of a command.
// Show number sends one frame per significant digit, most significant first,
//   units always at position 4; show digit and raw byte send one frame each.
//   The unused function code is taken and produces nothing.
// Path: the first frame of a command reaches m_axis_tvalid through the input
//   register, thousands stage, hundreds stage, set register and output
//   register.
// Throughput: one frame per cycle from the output register while m_axis_tready
//   is high; a number sends as many frames as it has digits (1 to 4), other
//   commands one frame each. The set register feeds the output register, so
//   the next command is taken while the current one is still being sent.
// Reset: synchronous, aresetn low clears all valid flags; nothing in flight
//   survives it.
// Stall: m_axis_tready low holds the output frame; the stages behind it fill
//   and then s_axis_tready drops until the receiver takes data again.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_frame_builder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // value[31:0], position[34:32], segments[42:35]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // frame[17:0], digit_pos[20:18]
    output logic             m_axis_tlast    // last frame of the command
);

    logic           set_valid;
    logic           set_ready;
    ssfb_pkg::set_t set_data;

    // clamp and decimal split
    ssfb_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (s_axis_tuser),
        .value     (s_axis_tdata[31:0]),
        .position  (s_axis_tdata[34:32]),
        .segments  (s_axis_tdata[42:35]),
        .set_valid (set_valid),
        .set_ready (set_ready),
        .set_data  (set_data)
    );

    // frame sequencing and output register
    ssfb_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .set_valid (set_valid),
        .set_ready (set_ready),
        .set_data  (set_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
